// ----- sv/positional_list_engine_top_defines.svh -----
// Assertion macros shared by the checker of the positional list engine.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_TOP_DEFINES_SVH

// Same-cycle implication, switched off while reset is held.
`define PLE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/positional_list_engine_pkg.sv -----
// Types, codes and constants of the positional list engine.
// Used by the cell, the controller, the top level and the checker; no dependencies.
package positional_list_engine_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 5;
  localparam int CNT_OUT_W    = 5;
  localparam int CAPACITY_DEF = 16;
  // Wide enough to hold the 1-based position of any cell up to the largest capacity.
  localparam int CMP_W        = 11;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOCATE = 2'd2,
    OP_GET    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_INDEX    = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } stat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_DONE
  } fsm_t;

  typedef struct packed {
    op_t                      opcode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    stat_t                    status;
    logic signed [DATA_W-1:0] data_out;
    logic [POS_W-1:0]         found_position;
    logic [CNT_OUT_W-1:0]     count_out;
  } out_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic                     ins_go;
    logic                     del_go;
    logic                     locate;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] value;
  } cell_ctl_t;

  // Search token that travels down the chain, one cell per cycle.
  typedef struct packed {
    logic                     live;
    logic                     hit;
    logic [POS_W-1:0]         found;
    logic signed [DATA_W-1:0] data;
  } scan_t;

endpackage

// ----- sv/ple_cell.sv -----
// One list cell: holds a single entry and its occupied flag, shifts with its neighbours
// and forwards the search token. Depends on positional_list_engine_pkg.
module ple_cell
  import positional_list_engine_pkg::*;
#(
  parameter int CELL_IDX = 0
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cell_ctl_t                ctl,
  input  logic signed [DATA_W-1:0] left_val,
  input  logic                     left_occ,
  input  logic signed [DATA_W-1:0] right_val,
  input  logic                     right_occ,
  input  scan_t                    tok_in,
  output logic signed [DATA_W-1:0] val_o,
  output logic                     occ_o,
  output scan_t                    tok_o
);

  localparam logic [CMP_W-1:0] MY_POS = CMP_W'(CELL_IDX + 1);

  logic signed [DATA_W-1:0] val_r, val_nxt;
  logic                     occ_r, occ_nxt;
  scan_t                    tok_r, tok_nxt;
  logic [CMP_W-1:0]         pos_c;
  logic                     at_pos;
  logic                     from_pos;
  logic                     match;

  assign pos_c    = CMP_W'(ctl.pos);
  assign at_pos   = MY_POS == pos_c;
  assign from_pos = MY_POS >= pos_c;

  always_comb begin
    val_nxt = val_r;
    occ_nxt = occ_r;
    if (ctl.ins_go) begin
      if (at_pos) begin
        val_nxt = ctl.value;
        occ_nxt = 1'b1;
      end else if (from_pos) begin
        val_nxt = left_val;
        occ_nxt = left_occ;
      end
    end else if (ctl.del_go && from_pos) begin
      val_nxt = right_val;
      occ_nxt = right_occ;
    end
  end

  // A locate takes the first occupied cell holding the key; a fetch takes the addressed cell.
  assign match = tok_in.live && !tok_in.hit && occ_r &&
                 (ctl.locate ? (val_r == ctl.value) : at_pos);

  always_comb begin
    tok_nxt = tok_in;
    if (match) begin
      tok_nxt.hit   = 1'b1;
      tok_nxt.found = POS_W'(CELL_IDX + 1);
      tok_nxt.data  = val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
      tok_r <= '0;
    end else begin
      occ_r <= occ_nxt;
      tok_r <= tok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_o = val_r;
  assign occ_o = occ_r;
  assign tok_o = tok_r;

endmodule

// ----- sv/ple_ctrl.sv -----
// Request sequencer of the positional list engine: checks each request against the
// count, drives the cell chain and holds the output register. Depends on the package.
module ple_ctrl
  import positional_list_engine_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_t       in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_t      out_data,
  output cell_ctl_t ctl,
  output scan_t     tok_inj,
  input  scan_t     tok_last
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  fsm_t            state_r, state_nxt;
  in_t             req_r, req_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  out_t            res_r, res_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_t            out_data_r, out_data_nxt;

  logic [XW-1:0]   pos_x;
  logic [XW-1:0]   cnt_x;
  logic            pos_zero;
  logic            beyond;
  logic            beyond_ins;
  logic            is_full;
  logic            is_empty;
  stat_t           exec_stat;
  logic            exec_ok;
  logic            scan_op;
  logic            out_load;

  assign pos_x      = XW'(req_r.position);
  assign cnt_x      = XW'(count_r);
  assign pos_zero   = pos_x == '0;
  assign beyond     = pos_x > cnt_x;
  assign beyond_ins = pos_x > (cnt_x + XW'(1));
  assign is_full    = count_r == CAP_C;
  assign is_empty   = count_r == '0;

  // Checks that can be settled from the count alone, before any cell is visited.
  always_comb begin
    case (req_r.opcode)
      OP_INSERT: begin
        if (pos_zero || beyond_ins) begin
          exec_stat = ST_INDEX;
        end else if (is_full) begin
          exec_stat = ST_FULL;
        end else begin
          exec_stat = ST_OK;
        end
      end
      OP_DELETE: begin
        if (is_empty) begin
          exec_stat = ST_EMPTY;
        end else if (pos_zero || beyond) begin
          exec_stat = ST_INDEX;
        end else begin
          exec_stat = ST_OK;
        end
      end
      OP_LOCATE: begin
        exec_stat = ST_OK;
      end
      default: begin
        exec_stat = (pos_zero || beyond) ? ST_INDEX : ST_OK;
      end
    endcase
  end

  assign exec_ok = exec_stat == ST_OK;
  assign scan_op = req_r.opcode != OP_INSERT;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = (exec_ok && scan_op) ? S_SCAN : S_DONE;
      end
      S_SCAN: begin
        if (tok_last.live) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State machine outputs.
  always_comb begin
    in_stall      = state_r != S_IDLE;
    ctl.ins_go    = (state_r == S_EXEC) && exec_ok && !scan_op;
    ctl.del_go    = (state_r == S_SCAN) && tok_last.live && (req_r.opcode == OP_DELETE);
    ctl.locate    = req_r.opcode == OP_LOCATE;
    ctl.pos       = req_r.position;
    ctl.value     = req_r.value;
    tok_inj       = '0;
    tok_inj.live  = (state_r == S_EXEC) && exec_ok && scan_op;
    out_load      = (state_r == S_DONE) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    req_nxt = ((state_r == S_IDLE) && in_valid) ? in_data : req_r;

    count_nxt = count_r;
    if (ctl.ins_go) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.del_go) begin
      count_nxt = count_r - CW'(1);
    end

    res_nxt = res_r;
    if (state_r == S_EXEC) begin
      res_nxt = '0;
      res_nxt.status = exec_stat;
    end else if ((state_r == S_SCAN) && tok_last.live) begin
      res_nxt = '0;
      if (ctl.locate) begin
        res_nxt.status = tok_last.hit ? ST_OK : ST_NOTFOUND;
        res_nxt.found_position = tok_last.hit ? tok_last.found : '0;
      end else begin
        res_nxt.status   = ST_OK;
        res_nxt.data_out = tok_last.data;
      end
    end

    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    out_data_nxt = out_data_r;
    if (out_load) begin
      out_data_nxt           = res_r;
      out_data_nxt.count_out = CNT_OUT_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- sv/positional_list_engine_top.sv -----
// Top level of the positional list engine: the request sequencer and a chain of CAPACITY
// list cells. Depends on positional_list_engine_pkg, ple_ctrl and ple_cell.
//
// Usage: a request beat on in_* (valid/stall) carries opcode, position and value; every
// request gives exactly one result beat on out_* with status, data, found position and
// the entry count after the operation. Requests are handled one at a time.
// Insert, and any request rejected by its count check, goes from the check step straight to
// the final step; delete, get and locate first wait while the search token walks the
// cell chain one cell per cycle before the result is known.
// A new request is taken as soon as the previous one has been written into the output
// register, even while that result is still waiting; the block then only waits in its
// final step if the earlier result has not yet been taken.
// When out_stall is high the result beat holds steady until it is taken.
// Reset (rst_n low, synchronous) empties the list and drops any pending result; entry
// contents are not cleared, as only occupied cells are ever read.
module positional_list_engine_top
  import positional_list_engine_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  cell_ctl_t                ctl;
  logic signed [DATA_W-1:0] val_w [CAPACITY];
  logic                     occ_w [CAPACITY];
  scan_t                    tok_w [CAPACITY+1];

  ple_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .ctl       (ctl),
    .tok_inj   (tok_w[0]),
    .tok_last  (tok_w[CAPACITY])
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] lv;
    logic                     lo;
    logic signed [DATA_W-1:0] rv;
    logic                     ro;

    if (g == 0) begin : g_first
      assign lv = '0;
      assign lo = 1'b0;
    end else begin : g_mid_l
      assign lv = val_w[g-1];
      assign lo = occ_w[g-1];
    end

    if (g == CAPACITY - 1) begin : g_last
      assign rv = '0;
      assign ro = 1'b0;
    end else begin : g_mid_r
      assign rv = val_w[g+1];
      assign ro = occ_w[g+1];
    end

    ple_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .left_val  (lv),
      .left_occ  (lo),
      .right_val (rv),
      .right_occ (ro),
      .tok_in    (tok_w[g]),
      .val_o     (val_w[g]),
      .occ_o     (occ_w[g]),
      .tok_o     (tok_w[g+1])
    );
  end

endmodule

// ----- sv/ple_chk.sv -----
// Port-level checker for the positional list engine, bound to the top level.
// Depends on positional_list_engine_pkg and positional_list_engine_top_defines.svh.
`include "positional_list_engine_top_defines.svh"

module ple_chk
  import positional_list_engine_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // A stalled result beat must be offered again unchanged.
  `PLE_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result beat changed while stalled")

  // Requests are serviced one at a time, so an accepted beat is followed by a stall.
  `PLE_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall, "request taken while another is in flight")

  // A failed request carries neither data nor a found position.
  `PLE_ASSERT_NOW(a_fail_clean, out_valid && (out_data.status != ST_OK), (out_data.data_out == '0) && (out_data.found_position == '0), "failed result carries data")

  // A full report only ever comes with the list at capacity.
  `PLE_ASSERT_NOW(a_full_count, out_valid && (out_data.status == ST_FULL), out_data.count_out == CNT_OUT_W'(CAPACITY), "full status with list below capacity")

  // A found position is only reported by a successful request.
  `PLE_ASSERT_NOW(a_found_ok, out_valid && (out_data.found_position != '0), out_data.status == ST_OK, "found position on a failed result")

endmodule

bind positional_list_engine_top ple_chk #(.CAPACITY(CAPACITY)) u_ple_chk (.*);

// ----- tb/sv/testbench.sv -----
// Self-checking bench for positional_list_engine_top: directed list operations, then
// random grow, shrink and mixed phases, with random idling on both channels.
// Depends on positional_list_engine_pkg and the engine RTL only.
module testbench;
  import positional_list_engine_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam int CALM_TAIL = 150;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  always #4 clk = ~clk;

  positional_list_engine_top #(.CAPACITY(CAP)) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  // Predicted list contents and length, advanced once per accepted request beat.
  logic signed [DATA_W-1:0] list_mem [CAP];
  logic [CNT_OUT_W-1:0]     list_len = '0;

  // The list as the stimulus generator expects it to be, used only to aim positions.
  logic signed [DATA_W-1:0] planned_list [$];

  in_t  pending_requests [$];
  out_t expected_results [$];
  out_t want;
  int   fault_count = 0;
  int   send_gap = 0;
  int   send_level = 0;
  int   send_cyc = 0;
  int   hold_left = 0;
  int   hold_level = 0;
  int   hold_cyc = 0;

  function automatic out_t apply_list_request(input in_t req);
    out_t rsp;
    int   len;
    int   pos;
    int   j;
    len = list_len;
    pos = req.position;
    rsp.status         = ST_OK;
    rsp.data_out       = '0;
    rsp.found_position = '0;
    case (req.opcode)
      OP_INSERT: begin
        if (pos < 1 || pos > len + 1) begin
          rsp.status = ST_INDEX;
        end else if (len == CAP) begin
          rsp.status = ST_FULL;
        end else begin
          for (j = len; j >= pos; j--) list_mem[j] = list_mem[j-1];
          list_mem[pos-1] = req.value;
          len++;
        end
      end
      OP_DELETE: begin
        if (len == 0) begin
          rsp.status = ST_EMPTY;
        end else if (pos < 1 || pos > len) begin
          rsp.status = ST_INDEX;
        end else begin
          rsp.data_out = list_mem[pos-1];
          for (j = pos - 1; j < len - 1; j++) list_mem[j] = list_mem[j+1];
          len--;
        end
      end
      OP_LOCATE: begin
        rsp.status = ST_NOTFOUND;
        for (j = 0; j < len && rsp.status == ST_NOTFOUND; j++) begin
          if (list_mem[j] == req.value) begin
            rsp.status         = ST_OK;
            rsp.found_position = POS_W'(j + 1);
          end
        end
      end
      OP_GET: begin
        if (pos < 1 || pos > len) rsp.status = ST_INDEX;
        else rsp.data_out = list_mem[pos-1];
      end
      default: ;
    endcase
    list_len = CNT_OUT_W'(len);
    rsp.count_out = list_len;
    return rsp;
  endfunction

  // Small values give plenty of duplicates for locate; the extremes turn up now and then.
  function automatic logic [DATA_W-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 3) return $urandom_range(0, 8) - 4;
    if (sel == 3) begin
      case ($urandom_range(0, 3))
        0: return 32'h7fff_ffff;
        1: return 32'h8000_0000;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    return $urandom;
  endfunction

  task automatic queue_request(input op_t op, input int pos, input logic [DATA_W-1:0] val);
    in_t req;
    req.opcode   = op;
    req.position = pos[POS_W-1:0];
    req.value    = val;
    pending_requests.push_back(req);
    case (op)
      OP_INSERT: begin
        if (pos >= 1 && pos <= planned_list.size() + 1 && planned_list.size() < CAP)
          planned_list.insert(pos - 1, val);
      end
      OP_DELETE: begin
        if (pos >= 1 && pos <= planned_list.size()) planned_list.delete(pos - 1);
      end
      default: ;
    endcase
  endtask

  // Request driver: a new beat is offered only once the previous one has been taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (send_cyc % 128 == 0) send_level = $urandom_range(0, 3);
      send_cyc++;
      if (in_valid && !in_stall) expected_results.push_back(apply_list_request(in_data));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() >= CALM_TAIL &&
                     $urandom_range(0, 11) < send_level) begin
          send_gap = $urandom_range(0, 13);
          in_valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          in_data  <= pending_requests.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver back-pressure.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("Unexpected result beat: status %0d data %0d found %0d count %0d",
                     out_data.status, out_data.data_out, out_data.found_position,
                     out_data.count_out);
        end else begin
          want = expected_results.pop_front();
          if (out_data.status !== want.status || out_data.data_out !== want.data_out ||
              out_data.found_position !== want.found_position ||
              out_data.count_out !== want.count_out) begin
            fault_count++;
            if (fault_count <= 10)
              $display({"Result mismatch (expected/actual): status %0d/%0d data %0d/%0d ",
                        "found %0d/%0d count %0d/%0d"},
                       want.status, out_data.status, want.data_out, out_data.data_out,
                       want.found_position, out_data.found_position,
                       want.count_out, out_data.count_out);
          end
        end
      end
      if (hold_cyc % 128 == 0) hold_level = $urandom_range(0, 3);
      hold_cyc++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (pending_requests.size() >= CALM_TAIL &&
                   $urandom_range(0, 11) < hold_level) begin
        hold_left = $urandom_range(0, 13);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    op_t op;
    int  n;
    int  pos;
    int  size;
    int  roll;
    int  phase_kind;
    int  phase_left;
    logic [DATA_W-1:0] val;

    // Directed opening: every failure status but the full one, both value extremes, both position extremes.
    queue_request(OP_GET,    1,  32'd5);
    queue_request(OP_DELETE, 1,  32'd0);
    queue_request(OP_LOCATE, 0,  32'd0);
    queue_request(OP_INSERT, 0,  32'd1);
    queue_request(OP_INSERT, 2,  32'd1);
    queue_request(OP_INSERT, 1,  32'h7fff_ffff);
    queue_request(OP_INSERT, 1,  32'h8000_0000);
    queue_request(OP_INSERT, 3,  32'hffff_ffff);
    queue_request(OP_INSERT, 2,  32'h0000_0000);
    queue_request(OP_INSERT, 31, 32'd9);
    queue_request(OP_GET,    0,  32'd0);
    queue_request(OP_GET,    4,  32'd0);
    queue_request(OP_GET,    5,  32'd0);
    queue_request(OP_GET,    31, 32'hffff_ffff);
    queue_request(OP_LOCATE, 31, 32'h7fff_ffff);
    queue_request(OP_LOCATE, 0,  32'd12345);
    queue_request(OP_INSERT, 5,  32'hffff_ffff);
    queue_request(OP_LOCATE, 0,  32'hffff_ffff);
    queue_request(OP_DELETE, 0,  32'd0);
    queue_request(OP_DELETE, 6,  32'd0);
    queue_request(OP_DELETE, 31, 32'd0);
    queue_request(OP_DELETE, 1,  32'd0);
    queue_request(OP_DELETE, 4,  32'd0);
    queue_request(OP_DELETE, 2,  32'd0);

    // Random phases: growing runs can reach a full list, shrinking runs can drain it to empty.
    phase_kind = 0;
    phase_left = 0;
    for (n = 0; n < 1200; n++) begin
      if (phase_left == 0) begin
        phase_kind = $urandom_range(0, 2);
        phase_left = $urandom_range(20, 60);
      end
      phase_left--;
      roll = $urandom_range(0, 99);
      if (phase_kind == 0) begin
        if (roll < 70) op = OP_INSERT;
        else if (roll < 80) op = OP_DELETE;
        else if (roll < 90) op = OP_LOCATE;
        else op = OP_GET;
      end else if (phase_kind == 1) begin
        if (roll < 15) op = OP_INSERT;
        else if (roll < 65) op = OP_DELETE;
        else if (roll < 82) op = OP_LOCATE;
        else op = OP_GET;
      end else begin
        op = op_t'($urandom_range(0, 3));
      end
      size = planned_list.size();
      if ($urandom_range(0, 99) < 15 || (size == 0 && op != OP_INSERT))
        pos = $urandom_range(0, 31);
      else if (op == OP_INSERT)
        pos = $urandom_range(1, size + 1);
      else
        pos = $urandom_range(1, size);
      if (op == OP_LOCATE && size > 0 && $urandom_range(0, 9) < 6)
        val = planned_list[$urandom_range(0, size - 1)];
      else
        val = pick_value();
      queue_request(op, pos, val);
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (pending_requests.size() != 0 || in_valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (CAP + 8) @(posedge clk);
    if (fault_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
